// ===== src/prlu_pkg.sv =====
// Shared types and constants of the PRINCE round layer unit.
// No dependencies; used by prlu_layer and prince_round_layer_unit_top.
package prlu_pkg;

  localparam int unsigned StateW = 64;
  localparam int unsigned OpW    = 3;
  localparam int unsigned NibN   = 16;
  localparam int unsigned LaneN  = 4;

  typedef logic [StateW-1:0] state_t;
  typedef logic [3:0]        nib_t;

  typedef enum logic [OpW-1:0] {
    OP_SBOX      = 3'd0,
    OP_SBOX_INV  = 3'd1,
    OP_SHIFT     = 3'd2,
    OP_SHIFT_INV = 3'd3,
    OP_MIX       = 3'd4
  } op_e;

  localparam nib_t SboxFwd [NibN] = '{
    4'hB, 4'hF, 4'h3, 4'h2, 4'hA, 4'hC, 4'h9, 4'h1,
    4'h6, 4'h7, 4'h8, 4'h0, 4'hE, 4'h5, 4'hD, 4'h4
  };

  localparam nib_t SboxInv [NibN] = '{
    4'hB, 4'h7, 4'h3, 4'h2, 4'hF, 4'hD, 4'h8, 4'h9,
    4'hA, 4'h6, 4'h4, 4'h0, 4'h5, 4'hE, 4'hC, 4'h1
  };

  localparam state_t LaneMask [LaneN] = '{
    64'hf000_f000_f000_f000,
    64'h0f00_0f00_0f00_0f00,
    64'h00f0_00f0_00f0_00f0,
    64'h000f_000f_000f_000f
  };

endpackage

// ===== src/prlu_layer.sv =====
// Combinational PRINCE layer: S-box, inverse S-box, shift rows, inverse
// shift rows and the M' mix layer. Depends on prlu_pkg.
module prlu_layer (
  input  logic [prlu_pkg::OpW-1:0] operation_i,
  input  prlu_pkg::state_t         state_i,
  output prlu_pkg::state_t         state_o
);
  import prlu_pkg::*;

  state_t sub_fwd;
  state_t sub_inv;
  state_t shf_fwd;
  state_t shf_inv;
  state_t mix;

  always_comb begin
    sub_fwd = '0;
    sub_inv = '0;
    for (int k = 0; k < NibN; k++) begin
      sub_fwd[4*k +: 4] = SboxFwd[state_i[4*k +: 4]];
      sub_inv[4*k +: 4] = SboxInv[state_i[4*k +: 4]];
    end
  end

  always_comb begin
    state_t lane;
    shf_fwd = '0;
    shf_inv = '0;
    for (int i = 0; i < LaneN; i++) begin
      lane    = state_i & LaneMask[i];
      shf_fwd = shf_fwd | (lane << (16 * i)) | (lane >> (StateW - 16 * i));
      shf_inv = shf_inv | (lane >> (16 * i)) | (lane << (StateW - 16 * i));
    end
  end

  always_comb begin
    nib_t       x [4];
    nib_t       all;
    nib_t       y;
    logic [1:0] excl;
    int         sh;
    mix = '0;
    for (int j = 0; j < 4; j++) begin
      sh = (j == 1 || j == 2) ? 1 : 0;
      for (int r = 0; r < 4; r++) begin
        x[r] = state_i[StateW-4-4*(4*r+j) +: 4];
      end
      all = x[0] ^ x[1] ^ x[2] ^ x[3];
      for (int r = 0; r < 4; r++) begin
        for (int b = 0; b < 4; b++) begin
          excl     = 2'(b + 8 - r - sh);
          y[3-b]   = all[3-b] ^ x[excl][3-b];
        end
        mix[StateW-4-4*(4*r+j) +: 4] = y;
      end
    end
  end

  always_comb begin
    case (op_e'(operation_i))
      OP_SBOX:      state_o = sub_fwd;
      OP_SBOX_INV:  state_o = sub_inv;
      OP_SHIFT:     state_o = shf_fwd;
      OP_SHIFT_INV: state_o = shf_inv;
      OP_MIX:       state_o = mix;
      default:      state_o = state_i;
    endcase
  end

endmodule

// ===== src/prince_round_layer_unit_top.sv =====
// PRINCE round layer unit: one cipher layer per transaction, selected by
// operation (0 S-box, 1 inverse S-box, 2 shift rows, 3 inverse shift rows,
// 4 M' mix; 5 to 7 pass the state through). A transaction is registered at
// the input, passes the layer logic and lands in the result register, from
// which the result is presented; one transaction is taken every cycle while
// the output is not stalled. Depends on prlu_pkg and prlu_layer.
module prince_round_layer_unit_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [prlu_pkg::OpW-1:0] operation_i,
  input  prlu_pkg::state_t         state_in_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output prlu_pkg::state_t         state_out_o
);
  import prlu_pkg::*;

  logic             in_valid_q;
  logic [OpW-1:0]   op_q;
  state_t           state_q;
  logic             out_valid_q;
  state_t           res_q;
  state_t           res_d;
  logic             out_ready;
  logic             in_ready;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_ready   = !in_valid_q || out_ready;
  assign in_stall_o = !in_ready;

  prlu_layer u_layer (
    .operation_i (op_q),
    .state_i     (state_q),
    .state_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      op_q    <= operation_i;
      state_q <= state_in_i;
    end
    if (out_ready && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign state_out_o = res_q;

endmodule

// ===== tb/sv/prince_round_layer_unit_top_test.sv =====
// Self-checking testbench for prince_round_layer_unit_top: drives directed and random layer
// transactions, predicts each state from its own layer model and compares every result.
// Depends on prlu_pkg and the unit under test only.
module prince_round_layer_unit_top_test;
  import prlu_pkg::*;

  localparam int unsigned HalfPeriod = 2;
  localparam int unsigned ResetCycles = 8;
  localparam int unsigned RandomPerPhase = 550;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned ReportLimit = 10;
  localparam int unsigned OpCodes = 2 ** OpW;

  typedef struct packed {
    logic [OpW-1:0] op;
    state_t         st;
  } layer_item_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_stall_o;
  logic [OpW-1:0] operation_i = '0;
  state_t         state_in_i = '0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  state_t         state_out_o;

  layer_item_t pending_q[$];
  state_t      expected_q[$];
  layer_item_t next_item;
  state_t      want_state;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  logic        hold_armed = 1'b0;
  logic        hold_done;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  int unsigned mismatches = 0;

  prince_round_layer_unit_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .state_in_i  (state_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .state_out_o (state_out_o)
  );

  always #HalfPeriod clk_i = ~clk_i;

  function automatic state_t layer_result(logic [OpW-1:0] op, state_t v);
    state_t      r;
    state_t      lane;
    nib_t        x [4];
    nib_t        all;
    nib_t        y;
    int unsigned s;
    int unsigned excl;
    int unsigned pos;
    r = '0;
    case (op)
      OP_SBOX: begin
        for (int k = 0; k < NibN; k++) r[4*k +: 4] = SboxFwd[v[4*k +: 4]];
      end
      OP_SBOX_INV: begin
        for (int k = 0; k < NibN; k++) r[4*k +: 4] = SboxInv[v[4*k +: 4]];
      end
      OP_SHIFT: begin
        for (int i = 0; i < LaneN; i++) begin
          lane = v & LaneMask[i];
          r |= (lane << (16 * i)) | (lane >> (StateW - 16 * i));
        end
      end
      OP_SHIFT_INV: begin
        for (int i = 0; i < LaneN; i++) begin
          lane = v & LaneMask[i];
          r |= (lane >> (16 * i)) | (lane << (StateW - 16 * i));
        end
      end
      OP_MIX: begin
        for (int j = 0; j < 4; j++) begin
          s = (j == 1 || j == 2) ? 1 : 0;
          all = '0;
          for (int row = 0; row < 4; row++) begin
            x[row] = v[60 - 4 * (4 * row + j) +: 4];
            all ^= x[row];
          end
          for (int row = 0; row < 4; row++) begin
            y = '0;
            for (int b = 0; b < 4; b++) begin
              excl = (b + 8 - row - s) % 4;
              y[3-b] = all[3-b] ^ x[excl][3-b];
            end
            pos = 60 - 4 * (4 * row + j);
            r[pos +: 4] = y;
          end
        end
      end
      default: r = v;
    endcase
    return r;
  endfunction

  task automatic add_item(logic [OpW-1:0] op, state_t st);
    layer_item_t it;
    it.op = op;
    it.st = st;
    pending_q.push_back(it);
  endtask

  task automatic add_random(int unsigned n);
    logic [OpW-1:0] op;
    state_t         st;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) op = OpW'($urandom_range(OP_MIX + 1, OpCodes - 1));
      else op = OpW'($urandom_range(OP_SBOX, OP_MIX));
      case ($urandom_range(0, 9))
        0: st = state_t'(1) << $urandom_range(0, StateW - 1);
        1: st = ~(state_t'(1) << $urandom_range(0, StateW - 1));
        2: st = state_t'($urandom_range(0, 15)) << (4 * $urandom_range(0, NibN - 1));
        default: st = {$urandom(), $urandom()};
      endcase
      add_item(op, st);
    end
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || expected_q.size() != 0 || in_valid_i) @(negedge clk_i);
  endtask

  // sender: hold the payload until taken, then offer the next item or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      operation_i <= '0;
      state_in_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) expected_q.push_back(layer_result(operation_i, state_in_i));
      if (!in_valid_i || !in_stall_o) begin
        if (pending_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          next_item = pending_q.pop_front();
          operation_i <= next_item.op;
          state_in_i  <= next_item.st;
          in_valid_i  <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off to back the unit up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_armed && !hold_done) begin
      out_stall_i <= 1'b1;
      hold_left   <= HoldCycles;
      hold_done   <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        if (mismatches < ReportLimit)
          $display("unexpected transaction: state_out %h", state_out_o);
        mismatches++;
      end else begin
        want_state = expected_q.pop_front();
        if (state_out_o !== want_state) begin
          if (mismatches < ReportLimit)
            $display("state_out mismatch: expected %h actual %h", want_state, state_out_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;

    tx_idle_pct = 25;
    rx_idle_pct = 71;
    for (int o = OP_SBOX; o <= OP_MIX; o++) begin
      add_item(OpW'(o), '0);
      add_item(OpW'(o), '1);
      add_item(OpW'(o), 64'h0123_4567_89ab_cdef);
      add_item(OpW'(o), 64'ha5a5_5a5a_f0f0_0f0f);
    end
    for (int o = OP_MIX + 1; o < OpCodes; o++) add_item(OpW'(o), 64'hfedc_ba98_7654_3210);
    add_random(RandomPerPhase);
    drain();

    @(negedge clk_i);
    tx_idle_pct = 71;
    rx_idle_pct = 25;
    add_random(RandomPerPhase);
    drain();

    @(negedge clk_i);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_armed  = 1'b1;
    add_random(RandomPerPhase);
    drain();

    repeat (SettleCycles) @(negedge clk_i);
    mismatches += expected_q.size();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
